// File: rtl/arm_multiply_unit_macros.svh
// Assertion macros used by the multiply unit top level.
`ifndef ARM_MULTIPLY_UNIT_MACROS_SVH
`define ARM_MULTIPLY_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: when a holds, c holds.
`define AMU_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("multiply unit assertion failed");
// Next-cycle implication: when a holds, c holds in the following cycle.
`define AMU_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("multiply unit assertion failed");
`else
`define AMU_ASSERT_IMPL(label, clk, rst_n, a, c)
`define AMU_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif

`endif

// File: rtl/amu_pkg.sv
// Types and codes of the multiply unit.
`default_nettype none
package amu_pkg;

	typedef enum logic [2:0] {
		CMD_MUL   = 3'd0,
		CMD_MLA   = 3'd1,
		CMD_UMULL = 3'd2,
		CMD_UMLAL = 3'd3,
		CMD_SMULL = 3'd4,
		CMD_SMLAL = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        set_flags;
		logic [31:0] rm_value;
		logic [31:0] rs_value;
		logic [31:0] acc_low;
		logic [31:0] acc_high;
	} req_t;

	typedef struct packed {
		logic [31:0] result_low;
		logic [31:0] result_high;
		logic        writes_high;
		logic        flags_update;
		logic        flag_negative;
		logic        flag_zero;
		logic [2:0]  internal_cycles;
	} rsp_t;

	// Decoded control that travels down the pipeline with each request.
	typedef struct packed {
		logic       valid_cmd;
		logic       is_long;
		logic       is_signed;
		logic       acc_low_en;
		logic       acc_high_en;
		logic       upd;
		logic [2:0] cycles;
	} ctrl_t;

endpackage
`default_nettype wire

// File: rtl/amu_decode.sv
// Operation decode and early-termination cycle count of the multiply unit.
`default_nettype none
module amu_decode (
	input  wire logic [2:0]  cmd,
	input  wire logic        set_flags,
	input  wire logic [31:0] rs_value,
	output amu_pkg::ctrl_t   ctrl
);
	import amu_pkg::*;

	logic       ones_ok;
	logic [2:0] m_cyc;
	logic [2:0] extra;

	// Count multiplier array passes: stop once the remaining upper bytes are all
	// zeros, or all ones for every form but UMULL and UMLAL.
	always_comb begin
		if (rs_value[31:8] == 24'h0 || (ones_ok && rs_value[31:8] == 24'hFFFFFF)) begin
			m_cyc = 3'd1;
		end else if (rs_value[31:16] == 16'h0 || (ones_ok && rs_value[31:16] == 16'hFFFF)) begin
			m_cyc = 3'd2;
		end else if (rs_value[31:24] == 8'h0 || (ones_ok && rs_value[31:24] == 8'hFF)) begin
			m_cyc = 3'd3;
		end else begin
			m_cyc = 3'd4;
		end
	end

	always_comb begin
		ctrl    = '0;
		ones_ok = 1'b1;
		extra   = 3'd0;
		unique case (cmd)
			CMD_MUL: begin
				ctrl.valid_cmd = 1'b1;
			end
			CMD_MLA: begin
				ctrl.valid_cmd  = 1'b1;
				ctrl.acc_low_en = 1'b1;
				extra           = 3'd1;
			end
			CMD_UMULL: begin
				ctrl.valid_cmd = 1'b1;
				ctrl.is_long   = 1'b1;
				ones_ok        = 1'b0;
				extra          = 3'd1;
			end
			CMD_UMLAL: begin
				ctrl.valid_cmd   = 1'b1;
				ctrl.is_long     = 1'b1;
				ctrl.acc_low_en  = 1'b1;
				ctrl.acc_high_en = 1'b1;
				ones_ok          = 1'b0;
				extra            = 3'd2;
			end
			CMD_SMULL: begin
				ctrl.valid_cmd = 1'b1;
				ctrl.is_long   = 1'b1;
				ctrl.is_signed = 1'b1;
				extra          = 3'd1;
			end
			CMD_SMLAL: begin
				ctrl.valid_cmd   = 1'b1;
				ctrl.is_long     = 1'b1;
				ctrl.is_signed   = 1'b1;
				ctrl.acc_low_en  = 1'b1;
				ctrl.acc_high_en = 1'b1;
				extra            = 3'd2;
			end
			default: begin
				ctrl.valid_cmd = 1'b0;
			end
		endcase
		ctrl.upd    = ctrl.valid_cmd & set_flags;
		// Undefined codes report a single cycle.
		ctrl.cycles = ctrl.valid_cmd ? (m_cyc + extra) : 3'd1;
	end

endmodule
`default_nettype wire

// File: rtl/arm_multiply_unit.sv
// Top level of the pipelined multiply and multiply-accumulate unit.
`default_nettype none
`include "arm_multiply_unit_macros.svh"
// Multiply unit for MUL, MLA, UMULL, UMLAL, SMULL and SMLAL. A request is taken
// on req when req_valid is high and req_stall low. Its response appears on rsp
// from the flag and response register, and is taken when rsp_valid is high and
// rsp_stall low. One request can enter every cycle while rsp_stall is low, so the
// sustained rate is one operation per cycle. There are five register stages,
// the first of which loads at the accepting edge: decode and operand
// capture, four 16x16 partial products, the 64-bit product sum with signed
// correction, the accumulate add, and the flag and response register.
// Each stage holds its own valid bit and advances whenever the stage after it
// is empty or moving, so bubbles close up under a stalled output and nothing is
// lost or repeated. Short forms give the low word with result_high zero; N and
// Z come from bit 31 and the low word for short forms, bit 63 and all 64 bits
// for long forms, and are computed even when set_flags is clear. Undefined
// command codes give an all-zero response with internal_cycles of one.
// internal_cycles is the early-termination count from the upper bytes of Rs,
// plus one for accumulation and one for a long result.
module arm_multiply_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output      logic         req_stall,
	input  wire amu_pkg::req_t req,
	output      logic         rsp_valid,
	input  wire logic         rsp_stall,
	output      amu_pkg::rsp_t rsp
);
	import amu_pkg::*;

	// Stage valid bits and advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	ctrl_t ctrl_in;
	ctrl_t ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;

	// Stage 1: operands and accumulator.
	logic [31:0] rm_s1, rs_s1;
	logic [63:0] acc_s1;

	// Stage 2: partial products and signed correction.
	logic [31:0] pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_hh_s2;
	logic [31:0] corr_s2;
	logic [63:0] acc_s2;

	// Stage 3: full product.
	logic [63:0] prod_s3;
	logic [63:0] acc_s3;
	logic [32:0] mid_sum;

	// Stage 4: result.
	logic [63:0] res_s4;
	logic [63:0] res_sum;

	rsp_t rsp_s5;

	amu_decode u_decode (
		.cmd       (req.cmd),
		.set_flags (req.set_flags),
		.rs_value  (req.rs_value),
		.ctrl      (ctrl_in)
	);

	// A stage advances when it is empty or the next stage advances.
	assign adv5 = !v_s5 || !rsp_stall;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign req_stall = !adv1;
	assign rsp_valid = v_s5;
	assign rsp       = rsp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// Stage 1: capture operands, select the accumulator the form uses.
	always_ff @(posedge clk) begin
		if (adv1) begin
			ctrl_s1 <= ctrl_in;
			rm_s1   <= req.rm_value;
			rs_s1   <= req.rs_value;
			acc_s1  <= {(ctrl_in.acc_high_en ? req.acc_high : 32'h0),
			            (ctrl_in.acc_low_en  ? req.acc_low  : 32'h0)};
		end
	end

	// Stage 2: four 16x16 partial products. A signed product differs from the
	// unsigned one only in the high word: subtract Rs when Rm is negative and
	// Rm when Rs is negative.
	always_ff @(posedge clk) begin
		if (adv2) begin
			ctrl_s2  <= ctrl_s1;
			pp_ll_s2 <= rm_s1[15:0]  * rs_s1[15:0];
			pp_lh_s2 <= rm_s1[15:0]  * rs_s1[31:16];
			pp_hl_s2 <= rm_s1[31:16] * rs_s1[15:0];
			pp_hh_s2 <= rm_s1[31:16] * rs_s1[31:16];
			corr_s2  <= ((ctrl_s1.is_signed && rm_s1[31]) ? rs_s1 : 32'h0)
			          + ((ctrl_s1.is_signed && rs_s1[31]) ? rm_s1 : 32'h0);
			acc_s2   <= acc_s1;
		end
	end

	// Stage 3: sum the partial products and apply the signed correction into the 64-bit product.
	assign mid_sum = {1'b0, pp_lh_s2} + {1'b0, pp_hl_s2};

	always_ff @(posedge clk) begin
		if (adv3) begin
			ctrl_s3 <= ctrl_s2;
			prod_s3 <= {pp_hh_s2 - corr_s2, pp_ll_s2} + {15'h0, mid_sum, 16'h0};
			acc_s3  <= acc_s2;
		end
	end

	// Stage 4: accumulate; drop the high word for short forms and zero the
	// result of an undefined code.
	assign res_sum = prod_s3 + acc_s3;

	always_ff @(posedge clk) begin
		if (adv4) begin
			ctrl_s4 <= ctrl_s3;
			res_s4  <= {(ctrl_s3.valid_cmd && ctrl_s3.is_long) ? res_sum[63:32] : 32'h0,
			            ctrl_s3.valid_cmd ? res_sum[31:0] : 32'h0};
		end
	end

	// Stage 5: flags and response register.
	always_ff @(posedge clk) begin
		if (adv5) begin
			rsp_s5.result_low      <= res_s4[31:0];
			rsp_s5.result_high     <= res_s4[63:32];
			rsp_s5.writes_high     <= ctrl_s4.valid_cmd && ctrl_s4.is_long;
			rsp_s5.flags_update    <= ctrl_s4.upd;
			rsp_s5.flag_negative   <= ctrl_s4.valid_cmd &&
			                          (ctrl_s4.is_long ? res_s4[63] : res_s4[31]);
			rsp_s5.flag_zero       <= ctrl_s4.valid_cmd &&
			                          (res_s4[31:0] == 32'h0) &&
			                          (!ctrl_s4.is_long || res_s4[63:32] == 32'h0);
			rsp_s5.internal_cycles <= ctrl_s4.cycles;
		end
	end

	// A request taken at the input occupies stage one next cycle.
	`AMU_ASSERT_NEXT(a_take_fills_s1, clk, arst_n, req_valid && !req_stall, v_s1)
	// Short forms never write a high word.
	`AMU_ASSERT_IMPL(a_short_high_zero, clk, arst_n,
		rsp_valid && !rsp.writes_high, rsp.result_high == 32'h0)
	// Cycle count stays between one and six.
	`AMU_ASSERT_IMPL(a_cycles_range, clk, arst_n, rsp_valid,
		rsp.internal_cycles >= 3'd1 && rsp.internal_cycles <= 3'd6)
	// Z agrees with the delivered result words.
	`AMU_ASSERT_IMPL(a_zero_consistent, clk, arst_n, rsp_valid && rsp.flag_zero,
		rsp.result_low == 32'h0 && rsp.result_high == 32'h0)
	// The input only stalls while stages one and two are both full.
	`AMU_ASSERT_IMPL(a_stall_only_full, clk, arst_n, req_stall, v_s1 && v_s2)

endmodule
`default_nettype wire
